@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the window median filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define RWM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define RWM_ASSERT(lbl, clk, rstn, prop)
`define RWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/rwm_pkg.sv @@
// ----------------------------------------------------------------------------
// rwm_pkg
// Shared constants, types and helpers of the RGB window median filter.
// ----------------------------------------------------------------------------
package rwm_pkg;

  localparam int unsigned WINDOW_DEF    = 3;
  localparam int unsigned MAX_WIDTH_DEF = 1024;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned PIXEL_W   = 3 * PIX_W;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned COL_OUT_W = 10;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;
  localparam logic [ROW_W-1:0] ROW_MAX     = 12'd4095;

  // Channel lanes inside a packed pixel word.
  localparam int unsigned CH_BLUE  = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_RED   = 2;

  typedef struct packed {
    logic                 valid;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;
  } meta_t;

  typedef struct packed {
    logic [PIX_W-1:0]     red;
    logic [PIX_W-1:0]     green;
    logic [PIX_W-1:0]     blue;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;
  } result_t;

  typedef enum logic [1:0] {
    BUF_EMPTY,
    BUF_ONE,
    BUF_FULL
  } buf_fill_e;

  // Row counter increment that sticks at its top value.
  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] row);
    logic [ROW_W-1:0] res;
    res = (row == ROW_MAX) ? row : row + ROW_W'(1);
    return res;
  endfunction

endpackage

@@ rtl/rwm_ram.sv @@
// ----------------------------------------------------------------------------
// rwm_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module rwm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rwm_line_window.sv @@
// ----------------------------------------------------------------------------
// rwm_line_window
// Column and row counting, line store read-modify-write and the pixel window.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rwm_line_window
  import rwm_pkg::*;
#(
  parameter int unsigned WINDOW    = WINDOW_DEF,
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                in_valid_i,
  input  logic                                sof_i,
  input  logic [PIXEL_W-1:0]                  pixel_i,
  input  logic [CFG_W-1:0]                    image_width_i,
  output logic [WINDOW*WINDOW*PIXEL_W-1:0]    win_o,
  output meta_t                               meta_o
);

  localparam int unsigned HALF  = WINDOW / 2;
  localparam int unsigned LINES = WINDOW - 1;
  localparam int unsigned TAPS  = WINDOW * WINDOW;
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW  = (WW > CFG_W) ? WW : CFG_W;
  localparam int unsigned CCW   = (CW > COL_OUT_W) ? CW : COL_OUT_W;
  localparam int unsigned LSW   = LINES * PIXEL_W;

  localparam logic [CMPW-1:0] W_MIN = CMPW'(WINDOW);
  localparam logic [CMPW-1:0] W_MAX = CMPW'(MAX_WIDTH);

  logic              accept;
  logic [CMPW-1:0]   width_raw;
  logic [CMPW-1:0]   width_eff;
  logic [CW-1:0]     col_start;
  logic [ROW_W-1:0]  row_start;
  logic [CW-1:0]     col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic              row_last;
  logic              emit;
  logic [CCW-1:0]    col_diff;
  logic [ROW_W-1:0]  row_centre;

  logic [CW-1:0]     col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;

  // Second stage: line store data is back and the window shifts.
  logic                  v1_q;
  logic [PIXEL_W-1:0]    px1_q;
  logic [CW-1:0]         c1_q;
  logic                  emit1_q;
  logic [COL_OUT_W-1:0]  ccol1_q;
  logic [ROW_W-1:0]      crow1_q;
  logic                  fwd1_q;
  logic [LSW-1:0]        fwd_data_q;

  logic [LSW-1:0]        ram_rdata;
  logic [LSW-1:0]        lines_old;
  logic [LSW-1:0]        lines_new;
  logic                  ram_we;

  logic [TAPS*PIXEL_W-1:0] win_q, win_d;
  meta_t                   meta_q;

  assign accept = in_valid_i && en_i;

  always_comb begin
    width_raw = CMPW'(image_width_i);
    if (width_raw < W_MIN) begin
      width_eff = W_MIN;
    end else if (width_raw > W_MAX) begin
      width_eff = W_MAX;
    end else begin
      width_eff = width_raw;
    end

    col_start = sof_i ? '0 : col_q;
    row_start = sof_i ? '0 : row_q;

    // A width shrunk in mid-row pushes this pixel to the next row.
    if (CMPW'(col_start) >= width_eff) begin
      col_cur = '0;
      row_cur = row_inc(row_start);
    end else begin
      col_cur = col_start;
      row_cur = row_start;
    end

    row_last = (CMPW'(col_cur) + CMPW'(1)) >= width_eff;
    if (row_last) begin
      col_d = '0;
      row_d = row_inc(row_cur);
    end else begin
      col_d = col_cur + CW'(1);
      row_d = row_cur;
    end

    emit = (CMPW'(col_cur) >= CMPW'(WINDOW - 1)) && (row_cur >= ROW_W'(WINDOW - 1));
    col_diff   = CCW'(col_cur) - CCW'(HALF);
    row_centre = (row_cur == ROW_MAX) ? ROW_MAX : row_cur - ROW_W'(HALF);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= accept;
    end
  end

  // The word written back by the second stage is forwarded when the next
  // pixel reads the same column in that cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px1_q      <= pixel_i;
      c1_q       <= col_cur;
      emit1_q    <= emit;
      ccol1_q    <= col_diff[COL_OUT_W-1:0];
      crow1_q    <= row_centre;
      fwd1_q     <= v1_q && (c1_q == col_cur);
      fwd_data_q <= lines_new;
    end
  end

  assign ram_we    = en_i && v1_q;
  assign lines_old = fwd1_q ? fwd_data_q : ram_rdata;

  generate
    if (LINES > 1) begin : g_multi_line
      assign lines_new = {lines_old[PIXEL_W*(LINES-1)-1:0], px1_q};
    end else begin : g_one_line
      assign lines_new = px1_q;
    end
  endgenerate

  rwm_ram #(
    .WIDTH (LSW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c1_q),
    .wdata_i (lines_new),
    .re_i    (accept),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    win_d = win_q;
    for (int rr = 0; rr < WINDOW; rr++) begin
      for (int cc = 0; cc < WINDOW - 1; cc++) begin
        win_d[PIXEL_W*(rr*WINDOW+cc) +: PIXEL_W] = win_q[PIXEL_W*(rr*WINDOW+cc+1) +: PIXEL_W];
      end
      if (rr < LINES) begin
        win_d[PIXEL_W*(rr*WINDOW+WINDOW-1) +: PIXEL_W] =
          lines_old[PIXEL_W*(LINES-1-rr) +: PIXEL_W];
      end else begin
        win_d[PIXEL_W*(rr*WINDOW+WINDOW-1) +: PIXEL_W] = px1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q.valid <= 1'b0;
    end else if (en_i) begin
      meta_q.valid <= v1_q && emit1_q;
      meta_q.col   <= ccol1_q;
      meta_q.row   <= crow1_q;
    end
  end

  assign win_o  = win_q;
  assign meta_o = meta_q;

  `RWM_ASSERT_NEXT(a_sof_restarts_row, clk_i, rst_ni, accept && sof_i, col_q == CW'(1))
  `RWM_ASSERT(a_centre_row_interior, clk_i, rst_ni,
              !meta_q.valid || (meta_q.row >= ROW_W'(HALF)))

endmodule

@@ rtl/rwm_median_sort.sv @@
// ----------------------------------------------------------------------------
// rwm_median_sort
// Pipelined odd-even transposition sort per color channel; the middle
// element of the last pass is the median.
// ----------------------------------------------------------------------------
module rwm_median_sort
  import rwm_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [WINDOW*WINDOW*PIXEL_W-1:0]  win_i,
  input  meta_t                             meta_i,
  output logic [PIX_W-1:0]                  red_o,
  output logic [PIX_W-1:0]                  green_o,
  output logic [PIX_W-1:0]                  blue_o,
  output meta_t                             meta_o
);

  localparam int unsigned TAPS = WINDOW * WINDOW;
  localparam int unsigned MID  = TAPS / 2;

  logic [TAPS*PIXEL_W-1:0] cur   [TAPS];
  logic [TAPS*PIXEL_W-1:0] nxt   [TAPS];
  logic [TAPS*PIXEL_W-1:0] stg_q [TAPS];
  meta_t                   meta_q [TAPS];

  always_comb begin
    cur[0] = win_i;
    for (int p = 1; p < TAPS; p++) begin
      cur[p] = stg_q[p-1];
    end
  end

  // Each pass compares disjoint neighbor pairs, alternating even and odd.
  always_comb begin
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    for (int p = 0; p < TAPS; p++) begin
      nxt[p] = cur[p];
      for (int ch = 0; ch < 3; ch++) begin
        for (int i = p % 2; i + 1 < TAPS; i += 2) begin
          lo = cur[p][PIXEL_W*i + PIX_W*ch +: PIX_W];
          hi = cur[p][PIXEL_W*(i+1) + PIX_W*ch +: PIX_W];
          if (lo > hi) begin
            nxt[p][PIXEL_W*i + PIX_W*ch +: PIX_W]     = hi;
            nxt[p][PIXEL_W*(i+1) + PIX_W*ch +: PIX_W] = lo;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int p = 0; p < TAPS; p++) begin
        stg_q[p] <= nxt[p];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < TAPS; p++) begin
        meta_q[p].valid <= 1'b0;
      end
    end else if (en_i) begin
      meta_q[0] <= meta_i;
      for (int p = 1; p < TAPS; p++) begin
        meta_q[p] <= meta_q[p-1];
      end
    end
  end

  assign red_o   = stg_q[TAPS-1][PIXEL_W*MID + PIX_W*CH_RED   +: PIX_W];
  assign green_o = stg_q[TAPS-1][PIXEL_W*MID + PIX_W*CH_GREEN +: PIX_W];
  assign blue_o  = stg_q[TAPS-1][PIXEL_W*MID + PIX_W*CH_BLUE  +: PIX_W];
  assign meta_o  = meta_q[TAPS-1];

endmodule

@@ rtl/rwm_out_buffer.sv @@
// ----------------------------------------------------------------------------
// rwm_out_buffer
// Two-word output buffer: an output register plus a skid register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rwm_out_buffer
  import rwm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t data_o
);

  buf_fill_e fill_q, fill_d;
  result_t   head_q, head_d;
  result_t   skid_q, skid_d;
  logic      pop;

  assign out_valid_o = (fill_q != BUF_EMPTY);
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    fill_d = fill_q;
    head_d = head_q;
    skid_d = skid_q;
    unique case (fill_q)
      BUF_EMPTY: begin
        if (push_i) begin
          head_d = data_i;
          fill_d = BUF_ONE;
        end
      end
      BUF_ONE: begin
        priority if (pop && push_i) begin
          head_d = data_i;
        end else if (pop) begin
          fill_d = BUF_EMPTY;
        end else if (push_i) begin
          skid_d = data_i;
          fill_d = BUF_FULL;
        end
      end
      BUF_FULL: begin
        if (pop) begin
          head_d = skid_q;
          fill_d = BUF_ONE;
        end
      end
      default: begin
        fill_d = BUF_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= BUF_EMPTY;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign space_o = (fill_q != BUF_FULL);
  assign data_o  = head_q;

  `RWM_ASSERT(a_no_push_when_full, clk_i, rst_ni, !push_i || (fill_q != BUF_FULL))
  `RWM_ASSERT_NEXT(a_drain_last_word, clk_i, rst_ni,
                   (fill_q == BUF_ONE) && !out_stall_i && !push_i, fill_q == BUF_EMPTY)

endmodule

@@ rtl/rgb_window_median_filter.sv @@
// The pixel that completes a window passes the second stage, the window register, the sort
// pass registers and the output buffer head; a stalled output holds its result word there.
// Throughput: one pixel per cycle unless halted; the line store RAM is read and written
// once per pixel. The pipeline halts only while both output buffer words are waiting.
// Reset: counters clear to column 0, row 0 and image width to 640; the line store is not
// cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// rgb_window_median_filter
// Streaming RGB median filter over a square window, one result per interior pixel.
// ----------------------------------------------------------------------------
module rgb_window_median_filter
  import rwm_pkg::*;
#(
  parameter int unsigned WINDOW    = WINDOW_DEF,
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 start_of_frame_i,
  input  logic [PIX_W-1:0]     red_in_i,
  input  logic [PIX_W-1:0]     green_in_i,
  input  logic [PIX_W-1:0]     blue_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIX_W-1:0]     red_median_o,
  output logic [PIX_W-1:0]     green_median_o,
  output logic [PIX_W-1:0]     blue_median_o,
  output logic [COL_OUT_W-1:0] centre_column_o,
  output logic [ROW_W-1:0]     centre_row_o
);

  localparam int unsigned TAPS = WINDOW * WINDOW;

  logic [CFG_W-1:0]        image_width_q;
  logic                    en;
  logic [TAPS*PIXEL_W-1:0] win;
  meta_t                   win_meta;
  meta_t                   sort_meta;
  logic [PIX_W-1:0]        med_red;
  logic [PIX_W-1:0]        med_green;
  logic [PIX_W-1:0]        med_blue;
  result_t                 res;
  result_t                 out_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= WIDTH_RESET;
    end else if (cfg_we_i) begin
      image_width_q <= cfg_wdata_i;
    end
  end

  rwm_line_window #(
    .WINDOW    (WINDOW),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .in_valid_i    (in_valid_i),
    .sof_i         (start_of_frame_i),
    .pixel_i       ({red_in_i, green_in_i, blue_in_i}),
    .image_width_i (image_width_q),
    .win_o         (win),
    .meta_o        (win_meta)
  );

  rwm_median_sort #(
    .WINDOW (WINDOW)
  ) u_median_sort (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .win_i   (win),
    .meta_i  (win_meta),
    .red_o   (med_red),
    .green_o (med_green),
    .blue_o  (med_blue),
    .meta_o  (sort_meta)
  );

  always_comb begin
    res.red   = med_red;
    res.green = med_green;
    res.blue  = med_blue;
    res.col   = sort_meta.col;
    res.row   = sort_meta.row;
  end

  rwm_out_buffer u_out_buffer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (en && sort_meta.valid),
    .data_i      (res),
    .space_o     (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_word)
  );

  assign in_stall_o      = !en;
  assign red_median_o    = out_word.red;
  assign green_median_o  = out_word.green;
  assign blue_median_o   = out_word.blue;
  assign centre_column_o = out_word.col;
  assign centre_row_o    = out_word.row;

endmodule
